>>> sv/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

   // default geometry
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // operation codes carried on the request tuser
   typedef enum logic [2:0] {
      FN_PUSH_FRONT = 3'd0,
      FN_PUSH_BACK  = 3'd1,
      FN_POP_FRONT  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_PEEK_FRONT = 3'd4,
      FN_PEEK_BACK  = 3'd5
   } func_type;

   // per-cycle command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CMD_HOLD        = 3'd0,
      CMD_TAKE_LEFT   = 3'd1,  // whole row moves one cell toward the back
      CMD_TAKE_RIGHT  = 3'd2,  // whole row moves one cell toward the front
      CMD_APPEND      = 3'd3,  // first free cell loads the pushed word
      CMD_DROP_LAST   = 3'd4   // last occupied cell empties itself
   } cell_cmd_type;

endpackage

>>> sv/double_ended_queue.sv
`timescale 1ns / 1ps
// The response word is registered and appears in the cycle after its request word is accepted.
// Throughput: one operation per cycle while each response word is taken; the row of cells updates in the cycle of the
// accept, and the response register frees as soon as the response word is taken.
// Reset: synchronous, clears every cell's occupied bit, the fill counter and the
// response valid; stored words are not cleared.
module double_ended_queue #(
   parameter int DEPTH      = dq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
   localparam int CountWidth  = $clog2(DEPTH + 1),
   localparam int InTdataW    = ((DATA_WIDTH + 7) / 8) * 8,
   localparam int OutFieldsW  = DATA_WIDTH + CountWidth + 2,
   localparam int OutTdataW   = ((OutFieldsW + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [InTdataW-1:0]   req_tdata,  // push_value
   input  logic [2:0]            req_tuser,  // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OutTdataW-1:0]  rsp_tdata,  // read_word, fill_count, is_empty, overflow
   output logic                  rsp_tuser   // found
);
   import dq_pkg::*;

   logic [DATA_WIDTH-1:0] cell_word [DEPTH];
   logic [DATA_WIDTH-1:0] cell_tail [DEPTH];
   logic [DEPTH-1:0]      cell_occ;

   logic                  req_accept;
   func_type              func;
   logic [DATA_WIDTH-1:0] push_value;
   cell_cmd_type          cmd_c, cmd;
   logic                  full, empty;
   logic [DATA_WIDTH-1:0] tail_word;

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rd_word_ff, rd_word_in;
   logic                  found_ff, found_in;
   logic                  ovf_ff, ovf_in;
   logic [CountWidth-1:0] rsp_count_ff;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign func       = func_type'(req_tuser);
   assign push_value = req_tdata[DATA_WIDTH-1:0];
   assign full       = cell_occ[DEPTH-1];
   assign empty      = !cell_occ[0];
   assign cmd        = req_accept ? cmd_c : CMD_HOLD;

   // row of cells, front at cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] lw, rw;
      logic                  lo, ro;
      if (i == 0) begin : g_first
         assign lw = push_value;
         assign lo = 1'b1;
      end else begin : g_mid
         assign lw = cell_word[i-1];
         assign lo = cell_occ[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rw = '0;
         assign ro = 1'b0;
      end else begin : g_inner
         assign rw = cell_word[i+1];
         assign ro = cell_occ[i+1];
      end
      dq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .push_word  (push_value),
         .left_word  (lw),
         .left_occ   (lo),
         .right_word (rw),
         .right_occ  (ro),
         .word       (cell_word[i]),
         .occ        (cell_occ[i]),
         .tail_word  (cell_tail[i])
      );
   end

   // back word: when not empty, exactly one cell drives its word on its tail; all others drive zero
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_word = tail_word | cell_tail[i];
      end
   end

   // decode the operation
   always_comb begin
      cmd_c      = CMD_HOLD;
      count_in   = count_ff;
      rd_word_in = '0;
      found_in   = 1'b0;
      ovf_in     = 1'b0;
      case (func)
         FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (full) begin
               ovf_in = 1'b1;
            end else begin
               cmd_c    = (func == FN_PUSH_FRONT) ? CMD_TAKE_LEFT : CMD_APPEND;
               count_in = count_ff + CountWidth'(1);
            end
         end
         FN_POP_FRONT, FN_PEEK_FRONT: begin
            if (!empty) begin
               rd_word_in = cell_word[0];
               found_in   = 1'b1;
               if (func == FN_POP_FRONT) begin
                  cmd_c    = CMD_TAKE_RIGHT;
                  count_in = count_ff - CountWidth'(1);
               end
            end
         end
         FN_POP_BACK, FN_PEEK_BACK: begin
            if (!empty) begin
               rd_word_in = tail_word;
               found_in   = 1'b1;
               if (func == FN_POP_BACK) begin
                  cmd_c    = CMD_DROP_LAST;
                  count_in = count_ff - CountWidth'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // fill counter and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            count_ff <= count_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_word_ff   <= rd_word_in;
         found_ff     <= found_in;
         ovf_ff       <= ovf_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = OutTdataW'({ovf_ff, (rsp_count_ff == '0), rsp_count_ff, rd_word_ff});

`ifndef SYNTHESIS
   // counter agrees with the occupied bits of the row
   assert property (@(posedge clock) disable iff (reset)
      count_ff == CountWidth'($countones(cell_occ)))
      else $error("fill counter out of step with cells");

   // occupied cells form one run starting at the front
   assert property (@(posedge clock) disable iff (reset)
      (cell_occ & (cell_occ + DEPTH'(1))) == '0)
      else $error("occupied cells not contiguous");

   // every accepted word yields a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("response missing after accept");

   // a push into a full row reports overflow and leaves the row alone
   assert property (@(posedge clock) disable iff (reset)
      req_accept && full && (func == FN_PUSH_FRONT || func == FN_PUSH_BACK)
      |=> ovf_ff && $stable(cell_occ))
      else $error("push on full not dropped");
`endif

endmodule

>>> sv/dq_cell.sv
`timescale 1ns / 1ps

module dq_cell #(
   parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dq_pkg::cell_cmd_type    cmd,
   input  logic [DATA_WIDTH-1:0]   push_word,
   input  logic [DATA_WIDTH-1:0]   left_word,
   input  logic                    left_occ,
   input  logic [DATA_WIDTH-1:0]   right_word,
   input  logic                    right_occ,
   output logic [DATA_WIDTH-1:0]   word,
   output logic                    occ,
   output logic [DATA_WIDTH-1:0]   tail_word
);
   import dq_pkg::*;

   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic                  occ_ff, occ_in;
   logic                  is_last;

   // this cell holds the back word when it is occupied and its right neighbor is not
   assign is_last   = occ_ff && !right_occ;
   assign word      = word_ff;
   assign occ       = occ_ff;
   assign tail_word = is_last ? word_ff : '0;

   // local next state from the broadcast command and the two neighbors
   always_comb begin
      word_in = word_ff;
      occ_in  = occ_ff;
      case (cmd)
         CMD_TAKE_LEFT: begin
            word_in = left_word;
            occ_in  = left_occ;
         end
         CMD_TAKE_RIGHT: begin
            word_in = right_word;
            occ_in  = right_occ;
         end
         CMD_APPEND: begin
            if (!occ_ff && left_occ) begin
               word_in = push_word;
               occ_in  = 1'b1;
            end
         end
         CMD_DROP_LAST: begin
            if (is_last) begin
               occ_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule
